@@ design/lfsc_pkg.sv @@
// Shared types and constants for the line follow steering controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lfsc_pkg;

   // Field widths
   localparam int CENTROID_W = 11;
   localparam int COVERAGE_W = 13;
   localparam int TIME_W     = 32;
   localparam int CMD_W      = 16;
   localparam int CONF_W     = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Control constants
   localparam int ERROR_SPAN   = 130;
   localparam int SEARCH_SPEED = 256;
   localparam int JUMP_LIMIT   = 140;
   localparam int SHARP_FWD    = 256;
   localparam logic [CONF_W-1:0] CONF_START = 5'd15;
   localparam logic [CONF_W-1:0] CONF_MAX   = 5'd18;

   // Speed scale table: entry m = ceil(2^SPEED_FRAC * (ERROR_SPAN - m) / ERROR_SPAN),
   // exact floor for any 15-bit cruise speed after the product is shifted down.
   localparam int SPEED_FRAC        = 23;
   localparam int SPEED_SCALE_W     = SPEED_FRAC + 1;
   localparam int SPEED_TABLE_DEPTH = (ERROR_SPAN + 1) / 2;
   localparam int SPEED_IDX_W       = $clog2(SPEED_TABLE_DEPTH);

   typedef logic [SPEED_SCALE_W-1:0] speed_scale_table_type [SPEED_TABLE_DEPTH];

   function automatic speed_scale_table_type build_speed_table();
      speed_scale_table_type t;
      longint num;
      for (int m = 0; m < SPEED_TABLE_DEPTH; m++) begin
         num  = (longint'(ERROR_SPAN - m) << SPEED_FRAC) + longint'(ERROR_SPAN - 1);
         t[m] = SPEED_SCALE_W'(num / ERROR_SPAN);
      end
      return t;
   endfunction

   localparam speed_scale_table_type SPEED_SCALE = build_speed_table();

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WAIT_MS            = 4'd0,
      REG_RESET_TIMEOUT_MS   = 4'd1,
      REG_CRUISE_SPEED       = 4'd2,
      REG_MIN_SPEED          = 4'd3,
      REG_STEER_GAIN         = 4'd4,
      REG_SHARP_TURN_RATE    = 4'd5,
      REG_COV_LIMIT          = 4'd6,
      REG_SEARCH_TURN_RATE   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] wait_ms;
      logic [15:0] reset_timeout_ms;
      logic [14:0] cruise_speed;
      logic [14:0] min_speed;
      logic [15:0] steer_gain;
      logic [14:0] sharp_turn_rate;
      logic [12:0] cov_limit;
      logic [14:0] search_turn_rate;
   } cfg_type;

   // Tracker to command logic
   typedef struct packed {
      logic signed [CENTROID_W-1:0] error;
      logic                         search_right;
   } track_info_type;

endpackage

@@ design/lfsc_cfg_regs.sv @@
// Configuration register file of the steering controller.
// Depends on lfsc_pkg for the register indexes and the cfg_type bundle.
`timescale 1ns / 1ps

module lfsc_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lfsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lfsc_pkg::cfg_type                cfg
);

   lfsc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lfsc_pkg::REG_WAIT_MS:            cfg_in.wait_ms            = csr_wdata;
            lfsc_pkg::REG_RESET_TIMEOUT_MS:   cfg_in.reset_timeout_ms   = csr_wdata;
            lfsc_pkg::REG_CRUISE_SPEED:       cfg_in.cruise_speed       = csr_wdata[14:0];
            lfsc_pkg::REG_MIN_SPEED:          cfg_in.min_speed          = csr_wdata[14:0];
            lfsc_pkg::REG_STEER_GAIN:         cfg_in.steer_gain         = csr_wdata;
            lfsc_pkg::REG_SHARP_TURN_RATE:    cfg_in.sharp_turn_rate    = csr_wdata[14:0];
            lfsc_pkg::REG_COV_LIMIT:          cfg_in.cov_limit          = csr_wdata[12:0];
            lfsc_pkg::REG_SEARCH_TURN_RATE:   cfg_in.search_turn_rate   = csr_wdata[14:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_ms            <= 16'd5000;
         cfg_ff.reset_timeout_ms   <= 16'd2000;
         cfg_ff.cruise_speed       <= 15'd2048;
         cfg_ff.min_speed          <= 15'd128;
         cfg_ff.steer_gain         <= 16'd524;
         cfg_ff.sharp_turn_rate    <= 15'd845;
         cfg_ff.cov_limit          <= 13'd942;
         cfg_ff.search_turn_rate   <= 15'd1784;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/lfsc_tracker.sv @@
// Centroid tracker: tracked position, confidence, heading memory and line timer.
// Depends on lfsc_pkg for widths, tracking constants and track_info_type.
`timescale 1ns / 1ps

module lfsc_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  update,
   input  logic                                  seen,
   input  logic signed [lfsc_pkg::CENTROID_W-1:0] centroid_x,
   input  logic [lfsc_pkg::TIME_W-1:0]           now_ms,
   input  logic [15:0]                           reset_timeout_ms,
   output lfsc_pkg::track_info_type              info
);

   localparam int CW = lfsc_pkg::CENTROID_W;

   logic signed [CW-1:0]           tracked_ff, tracked_in;
   logic                           active_ff, active_in;
   logic [lfsc_pkg::CONF_W-1:0]    conf_ff, conf_in;
   logic                           heading_ff, heading_in;
   logic                           neg_ff, neg_in;
   logic [lfsc_pkg::TIME_W-1:0]    last_ff, last_in;

   logic signed [CW:0]             diff;
   logic [CW:0]                    abs_diff;
   logic                           jump_ok;
   logic [lfsc_pkg::TIME_W-1:0]    elapsed;

   assign diff     = {centroid_x[CW-1], centroid_x} - {tracked_ff[CW-1], tracked_ff};
   assign abs_diff = diff[CW] ? (CW+1)'(-diff) : diff;
   assign jump_ok  = abs_diff < (CW+1)'(lfsc_pkg::JUMP_LIMIT);
   assign elapsed  = now_ms - last_ff;

   always_comb begin
      tracked_in = tracked_ff;
      active_in  = active_ff;
      conf_in    = conf_ff;
      heading_in = heading_ff;
      neg_in     = neg_ff;
      last_in    = last_ff;
      if (seen) begin
         last_in = now_ms;
         // restart on a new track, or when a rejected jump drains confidence
         if (!active_ff || (!jump_ok && conf_ff <= lfsc_pkg::CONF_W'(1))) begin
            tracked_in = centroid_x;
            active_in  = 1'b1;
            conf_in    = lfsc_pkg::CONF_START;
         end else if (jump_ok) begin
            tracked_in = centroid_x;
            if (conf_ff < lfsc_pkg::CONF_MAX) conf_in = conf_ff + lfsc_pkg::CONF_W'(1);
         end else begin
            conf_in = conf_ff - lfsc_pkg::CONF_W'(1);
         end
         heading_in = 1'b1;
         neg_in     = tracked_in[CW-1];
      end else begin
         if (active_ff) begin
            if (conf_ff != '0) conf_in = conf_ff - lfsc_pkg::CONF_W'(1);
            if (conf_ff <= lfsc_pkg::CONF_W'(1)) active_in = 1'b0;
         end
         if (elapsed >= {16'b0, reset_timeout_ms}) begin
            tracked_in = '0;
            active_in  = 1'b0;
            conf_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff <= '0;
         active_ff  <= 1'b0;
         conf_ff    <= '0;
         heading_ff <= 1'b0;
         neg_ff     <= 1'b0;
         last_ff    <= '0;
      end else if (update) begin
         tracked_ff <= tracked_in;
         active_ff  <= active_in;
         conf_ff    <= conf_in;
         heading_ff <= heading_in;
         neg_ff     <= neg_in;
         last_ff    <= last_in;
      end
   end

   // error is the post-update position; only used when a line is seen
   assign info.error        = tracked_in;
   assign info.search_right = heading_ff && !neg_ff;

   a_conf_bound: assert property (@(posedge clock) disable iff (reset)
      conf_ff <= lfsc_pkg::CONF_MAX)
      else $error("confidence above its ceiling");

   a_active_conf: assert property (@(posedge clock) disable iff (reset)
      active_ff == (conf_ff != '0))
      else $error("tracking flag disagrees with confidence");

   a_seen_tracks: assert property (@(posedge clock) disable iff (reset)
      (update && seen) |=> (active_ff && heading_ff && last_ff == $past(now_ms)))
      else $error("line request did not refresh tracking");

endmodule

@@ design/lfsc_command.sv @@
// Command logic: forward speed and turn rate from the tracked error and coverage.
// Depends on lfsc_pkg for constants, the speed scale table and the bundles.
`timescale 1ns / 1ps

module lfsc_command (
   input  logic                                  seen,
   input  logic [lfsc_pkg::COVERAGE_W-1:0]       coverage,
   input  lfsc_pkg::track_info_type              info,
   input  lfsc_pkg::cfg_type                     cfg,
   output logic signed [lfsc_pkg::CMD_W-1:0]     forward_speed,
   output logic signed [lfsc_pkg::CMD_W-1:0]     turn_rate
);

   localparam int CW  = lfsc_pkg::CENTROID_W;
   localparam int FW  = lfsc_pkg::SPEED_SCALE_W;
   localparam int PW  = CW + 17;   // error x {0,gain}

   logic [CW-1:0]                   mag;
   logic                            near;
   logic [lfsc_pkg::SPEED_IDX_W-1:0] idx;
   logic [FW-1:0]                   factor;
   logic [15+FW-1:0]                speed_prod;
   logic [14:0]                     speed_prop;
   logic [14:0]                     speed_base;
   logic [14:0]                     speed_cmd;
   logic signed [PW-1:0]            steer_prod;
   logic signed [PW:0]              steer_round;
   logic signed [PW-8:0]            steer_shift;
   logic signed [15:0]              steer_sat;
   logic signed [15:0]              sharp_pos, search_pos;

   assign mag  = info.error[CW-1] ? CW'(-info.error) : info.error;
   assign near = {1'b0, mag, 1'b0} < (CW+2)'(lfsc_pkg::ERROR_SPAN);
   assign idx  = near ? mag[lfsc_pkg::SPEED_IDX_W-1:0] : '0;

   assign factor     = lfsc_pkg::SPEED_SCALE[idx];
   assign speed_prod = cfg.cruise_speed * factor;
   assign speed_prop = speed_prod[lfsc_pkg::SPEED_FRAC +: 15];
   assign speed_base = near ? speed_prop : {1'b0, cfg.cruise_speed[14:1]};
   assign speed_cmd  = (speed_base < cfg.min_speed) ? cfg.min_speed : speed_base;

   // -(e * gain) + 1/2, then floor by 256
   assign steer_prod  = info.error * $signed({1'b0, cfg.steer_gain});
   assign steer_round = (PW+1)'(-$signed({steer_prod[PW-1], steer_prod})) + (PW+1)'(128);
   assign steer_shift = steer_round[PW:8];

   always_comb begin
      if (steer_shift > (PW-7)'(32767))
         steer_sat = 16'sd32767;
      else if (steer_shift < -(PW-7)'(32768))
         steer_sat = -16'sd32768;
      else
         steer_sat = steer_shift[15:0];
   end

   assign sharp_pos  = {1'b0, cfg.sharp_turn_rate};
   assign search_pos = {1'b0, cfg.search_turn_rate};

   always_comb begin
      if (!seen) begin
         forward_speed = 16'(lfsc_pkg::SEARCH_SPEED);
         turn_rate     = info.search_right ? -search_pos : search_pos;
      end else if (coverage >= cfg.cov_limit) begin
         forward_speed = 16'(lfsc_pkg::SHARP_FWD);
         turn_rate     = info.error[CW-1] ? sharp_pos : -sharp_pos;
      end else begin
         forward_speed = {1'b0, speed_cmd};
         turn_rate     = steer_sat;
      end
   end

endmodule

@@ design/line_follow_steering_controller_top.sv @@
// Line follow steering controller: one steering request in, at most one command out.
// A request held in the input stage is issued to the output stage once rsp is free; its command then shows on rsp.
// Throughput: one request per cycle while rsp is not stalled; the tracker state loop closes through its registers.
// Requests before the start-up wait has passed are consumed and give no command.
// Reset (synchronous, active high) clears tracking, both stages and loads default
// registers; no clearing pass is needed.
`timescale 1ns / 1ps

module line_follow_steering_controller_top (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // centroid_x[10:0], coverage[23:11], now_ms[55:24]
   input  logic [0:0]  req_tuser,   // line_seen[0]
   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // forward_speed[15:0], turn_rate[31:16]
   // configuration
   input  logic                             csr_we,
   input  logic [lfsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = lfsc_pkg::CENTROID_W;

   lfsc_pkg::cfg_type         cfg;
   lfsc_pkg::track_info_type  info;

   // input stage
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_seen_ff;
   logic signed [CW-1:0]              s1_cx_ff;
   logic [lfsc_pkg::COVERAGE_W-1:0]   s1_cov_ff;
   logic [lfsc_pkg::TIME_W-1:0]       s1_now_ff;

   // output stage
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]                rsp_fwd_ff, rsp_turn_ff;

   logic signed [15:0]                fwd_cmd, turn_cmd;
   logic req_accept, out_free, s1_active, s1_go, issue;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_active  = s1_now_ff >= {16'b0, cfg.wait_ms};
   // a request in the wait window leaves without needing the output
   assign s1_go      = s1_valid_ff && (!s1_active || out_free);
   assign issue      = s1_go && s1_active;
   assign req_tready = !s1_valid_ff || s1_go;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = issue ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_seen_ff <= req_tuser[0];
         s1_cx_ff   <= req_tdata[10:0];
         s1_cov_ff  <= req_tdata[23:11];
         s1_now_ff  <= req_tdata[55:24];
      end
      if (issue) begin
         rsp_fwd_ff  <= fwd_cmd;
         rsp_turn_ff <= turn_cmd;
      end
   end

   lfsc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfsc_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .update           (issue),
      .seen             (s1_seen_ff),
      .centroid_x       (s1_cx_ff),
      .now_ms           (s1_now_ff),
      .reset_timeout_ms (cfg.reset_timeout_ms),
      .info             (info)
   );

   lfsc_command u_command (
      .seen          (s1_seen_ff),
      .coverage      (s1_cov_ff),
      .info          (info),
      .cfg           (cfg),
      .forward_speed (fwd_cmd),
      .turn_rate     (turn_cmd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_turn_ff, rsp_fwd_ff};

   a_issue_shows: assert property (@(posedge clock) disable iff (reset)
      issue |=> (rsp_tvalid && rsp_tdata == $past({turn_cmd, fwd_cmd})))
      else $error("issued command not presented");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_active && !out_free) |=> (s1_valid_ff && $stable(s1_now_ff)))
      else $error("pending request lost during output stall");

   a_wait_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_active && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("command issued during start-up wait");

endmodule
